>>> rtl/lrd_pkg.sv
// shared widths and payload types for the line rasterizer
package lrd_pkg;

  localparam int unsigned CoordBits = 9;
  localparam int unsigned WalkBits  = CoordBits + 1;
  localparam int unsigned LimitBits = 9;
  localparam int unsigned ColorBits = 16;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [LimitBits-1:0] WidthLimitReset  = LimitBits'(240);
  localparam logic [LimitBits-1:0] HeightLimitReset = LimitBits'(240);
  localparam logic [ColorBits-1:0] ColorReset       = '0;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgWidthLimit  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgHeightLimit = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgDrawColor   = 2'd2;

  // request opcodes
  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;

  // walk direction codes
  localparam logic [1:0] DirNone  = 2'd0;
  localparam logic [1:0] DirPlus  = 2'd1;
  localparam logic [1:0] DirMinus = 2'd3;

  typedef struct packed {
    logic                 op;
    logic [CoordBits-1:0] x_start;
    logic [CoordBits-1:0] y_start;
    logic [CoordBits-1:0] x_end;
    logic [CoordBits-1:0] y_end;
  } lrd_in_t;

  typedef struct packed {
    logic                 point_valid;
    logic [WalkBits-1:0]  point_x;
    logic [WalkBits-1:0]  point_y;
    logic [ColorBits-1:0] point_color;
    logic                 last_point;
    logic                 rejected;
  } lrd_out_t;

endpackage

>>> rtl/line_rasterizer_dda.sv
// line rasterizer top level: start/step command decode, dda walk and result buffer
//
//  channel  direction  handshake        payload
//  in       input      valid / stall    lrd_in_t  (op, endpoints)
//  out      output     valid / stall    lrd_out_t (point or reject flag)
//  cfg      input      valid / ready    index, data (limits, color)
//
// one request per cycle while in_stall_o is low: a step is one add and compare per
// axis on the walk registers; its result is registered in the output register, or
// in the skid entry if the output stalls. a start within the limits gives no result.
// reset idles the walk and loads the default limits and color.
// a two-entry output buffer lets one more request in while the downstream stalls.
module line_rasterizer_dda
  import lrd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  lrd_in_t                in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output lrd_out_t               out_res_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  localparam int unsigned CmpBits = (CoordBits > LimitBits) ? CoordBits : LimitBits;

  logic [LimitBits-1:0] width_limit_q, height_limit_q;
  logic [ColorBits-1:0] draw_color_q;

  logic                 active_q, active_d;
  logic [WalkBits-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CoordBits-1:0] abs_dx_q, abs_dx_d, abs_dy_q, abs_dy_d;
  logic [CoordBits-1:0] major_q, major_d;
  logic [WalkBits-1:0]  acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [1:0]           dir_x_q, dir_x_d, dir_y_q, dir_y_d;
  logic [WalkBits-1:0]  left_q, left_d;

  logic                 out_valid_q, skid_valid_q;
  lrd_out_t             out_q, skid_q;

  logic                 accept, out_take, produce;
  lrd_out_t             res;

  // start decode
  logic                 reject;
  logic [CoordBits-1:0] dx_mag, dy_mag, new_major;
  logic [1:0]           dx_dir, dy_dir;

  // step arithmetic
  logic [WalkBits:0]    sum_x, sum_y, major_ext;
  logic [WalkBits-1:0]  move_x, move_y;
  logic                 last;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i & ~skid_valid_q;
  assign out_take    = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  function automatic logic [WalkBits-1:0] axis_move(logic [WalkBits-1:0] pos,
                                                    logic [1:0] dir);
    logic [WalkBits-1:0] r;
    case (dir)
      DirPlus:  r = pos + WalkBits'(1);
      DirMinus: r = pos - WalkBits'(1);
      default:  r = pos;
    endcase
    return r;
  endfunction

  always_comb begin
    reject = (CmpBits'(in_req_i.x_start) > CmpBits'(width_limit_q))
           | (CmpBits'(in_req_i.x_end)   > CmpBits'(width_limit_q))
           | (CmpBits'(in_req_i.y_start) > CmpBits'(height_limit_q))
           | (CmpBits'(in_req_i.y_end)   > CmpBits'(height_limit_q));

    if (in_req_i.x_end > in_req_i.x_start) begin
      dx_mag = in_req_i.x_end - in_req_i.x_start;
      dx_dir = DirPlus;
    end else if (in_req_i.x_end < in_req_i.x_start) begin
      dx_mag = in_req_i.x_start - in_req_i.x_end;
      dx_dir = DirMinus;
    end else begin
      dx_mag = '0;
      dx_dir = DirNone;
    end
    if (in_req_i.y_end > in_req_i.y_start) begin
      dy_mag = in_req_i.y_end - in_req_i.y_start;
      dy_dir = DirPlus;
    end else if (in_req_i.y_end < in_req_i.y_start) begin
      dy_mag = in_req_i.y_start - in_req_i.y_end;
      dy_dir = DirMinus;
    end else begin
      dy_mag = '0;
      dy_dir = DirNone;
    end
    new_major = (dx_mag > dy_mag) ? dx_mag : dy_mag;

    // error accumulators, reduced by the major delta on overflow
    major_ext = (WalkBits + 1)'(major_q);
    sum_x     = {1'b0, acc_x_q} + (WalkBits + 1)'(abs_dx_q);
    sum_y     = {1'b0, acc_y_q} + (WalkBits + 1)'(abs_dy_q);
    move_x    = axis_move(cur_x_q, dir_x_q);
    move_y    = axis_move(cur_y_q, dir_y_q);
    last      = (left_q <= WalkBits'(1));

    active_d = active_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    abs_dx_d = abs_dx_q;
    abs_dy_d = abs_dy_q;
    major_d  = major_q;
    acc_x_d  = acc_x_q;
    acc_y_d  = acc_y_q;
    dir_x_d  = dir_x_q;
    dir_y_d  = dir_y_q;
    left_d   = left_q;
    produce  = 1'b0;
    res      = '0;

    if (accept) begin
      if (in_req_i.op == OpStart) begin
        if (reject) begin
          active_d     = 1'b0;
          left_d       = '0;
          produce      = 1'b1;
          res.rejected = 1'b1;
        end else begin
          abs_dx_d = dx_mag;
          abs_dy_d = dy_mag;
          dir_x_d  = dx_dir;
          dir_y_d  = dy_dir;
          major_d  = new_major;
          cur_x_d  = WalkBits'(in_req_i.x_start);
          cur_y_d  = WalkBits'(in_req_i.y_start);
          acc_x_d  = '0;
          acc_y_d  = '0;
          left_d   = WalkBits'(new_major) + WalkBits'(2);
          active_d = 1'b1;
        end
      end else if (active_q) begin
        produce         = 1'b1;
        res.point_valid = 1'b1;
        res.point_x     = cur_x_q;
        res.point_y     = cur_y_q;
        res.point_color = draw_color_q;
        res.last_point  = last;
        if (sum_x > major_ext) begin
          acc_x_d = WalkBits'(sum_x - major_ext);
          cur_x_d = move_x;
        end else begin
          acc_x_d = WalkBits'(sum_x);
        end
        if (sum_y > major_ext) begin
          acc_y_d = WalkBits'(sum_y - major_ext);
          cur_y_d = move_y;
        end else begin
          acc_y_d = WalkBits'(sum_y);
        end
        if (last) begin
          left_d   = '0;
          active_d = 1'b0;
        end else begin
          left_d = left_q - WalkBits'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_limit_q  <= WidthLimitReset;
      height_limit_q <= HeightLimitReset;
      draw_color_q   <= ColorReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgWidthLimit:  width_limit_q  <= cfg_data_i[LimitBits-1:0];
        CfgHeightLimit: height_limit_q <= cfg_data_i[LimitBits-1:0];
        CfgDrawColor:   draw_color_q   <= cfg_data_i[ColorBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      abs_dx_q <= '0;
      abs_dy_q <= '0;
      major_q  <= '0;
      acc_x_q  <= '0;
      acc_y_q  <= '0;
      dir_x_q  <= DirNone;
      dir_y_q  <= DirNone;
      left_q   <= '0;
    end else begin
      active_q <= active_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      abs_dx_q <= abs_dx_d;
      abs_dy_q <= abs_dy_d;
      major_q  <= major_d;
      acc_x_q  <= acc_x_d;
      acc_y_q  <= acc_y_d;
      dir_x_q  <= dir_x_d;
      dir_y_q  <= dir_y_d;
      left_q   <= left_d;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (produce) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (produce) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

endmodule
